/* design/gss_pkg.sv */
// Shared types and constants of the Gray-Scott stencil update block.
package gss_pkg;

  // Field and bus widths
  localparam int VAL_W   = 16;
  localparam int COL_W   = 6 * VAL_W;
  localparam int RES_W   = 2 * VAL_W;
  localparam int CIDX_W  = 3;

  // Job queue between the window front end and the arithmetic back end
  localparam int QDEPTH  = 4;
  localparam int QPTR_W  = $clog2(QDEPTH);
  localparam int QCNT_W  = $clog2(QDEPTH + 1);

  // Configuration register indexes
  typedef enum logic [CIDX_W-1:0] {
    REG_DIFF_A = 3'd0,
    REG_DIFF_B = 3'd1,
    REG_FEED   = 3'd2,
    REG_KILL   = 3'd3,
    REG_DT     = 3'd4
  } cfg_index_t;

  // Register reset values, UQ2.14
  localparam logic [VAL_W-1:0] DIFF_A_RST = 16'd16384;
  localparam logic [VAL_W-1:0] DIFF_B_RST = 16'd8192;
  localparam logic [VAL_W-1:0] FEED_RST   = 16'd901;
  localparam logic [VAL_W-1:0] KILL_RST   = 16'd1016;
  localparam logic [VAL_W-1:0] DT_RST     = 16'd8192;

  // One input column; up_a sits in the lowest bits
  typedef struct packed {
    logic [VAL_W-1:0] down_b;
    logic [VAL_W-1:0] down_a;
    logic [VAL_W-1:0] mid_b;
    logic [VAL_W-1:0] mid_a;
    logic [VAL_W-1:0] up_b;
    logic [VAL_W-1:0] up_a;
  } column_t;

  // One pixel to update: its 3x3 neighborhood and the end-of-row mark
  typedef struct packed {
    logic    done;
    column_t right;
    column_t centre;
    column_t left;
  } job_t;

  // Jobs pushed by the front end in one cycle (count is 0, 1 or 2)
  typedef struct packed {
    logic [1:0] n;
    job_t       j1;
    job_t       j0;
  } gss_push_t;

  // Rate registers as seen by the back end
  typedef struct packed {
    logic [VAL_W-1:0] diff_a;
    logic [VAL_W-1:0] diff_b;
    logic [VAL_W-1:0] feed;
    logic [VAL_W-1:0] kill;
    logic [VAL_W-1:0] dt;
  } gss_cfg_t;

  // Rounding and divider constants
  localparam logic signed [55:0] BR_ROUND = 56'sd163840;   // half of 20 * 2^14
  localparam logic [43:0]        DIV_BIAS = 44'd5 << 38;   // keeps dividend positive
  localparam logic [43:0]        Q_BIAS   = 44'd1 << 38;   // DIV_BIAS / 5
  localparam logic signed [55:0] DT_ROUND = 56'sd1 <<< 27; // half of 2^28
  localparam logic [23:0]        RECIP5   = 24'd13421773;  // ceil(2^26 / 5)

endpackage

/* design/gss_front.sv */
// Column window front end: holds two columns and issues pixel jobs.
module gss_front (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     s_axis_tvalid,
  output logic                     s_axis_tready,
  input  logic [gss_pkg::COL_W-1:0] s_axis_tdata,
  input  logic                     s_axis_tlast,
  input  logic                     room2,
  output gss_pkg::gss_push_t       push
);
  import gss_pkg::*;

  typedef enum logic [2:0] {
    WIN_EMPTY = 3'b001,
    WIN_ONE   = 3'b010,
    WIN_TWO   = 3'b100
  } win_t;

  win_t    win;
  column_t left;
  column_t centre;
  column_t x;
  logic    accept;

  assign s_axis_tready = room2;
  assign accept        = s_axis_tvalid & s_axis_tready;
  assign x             = column_t'(s_axis_tdata);

  // Build the jobs that this column completes
  always_comb begin
    push    = '0;
    push.j0 = '{done: 1'b0, right: x, centre: centre, left: left};
    push.j1 = '{done: 1'b1, right: x, centre: x, left: centre};
    case (win)
      WIN_EMPTY: begin
        push.j0 = '{done: 1'b1, right: x, centre: x, left: x};
        push.n  = (accept && s_axis_tlast) ? 2'd1 : 2'd0;
      end
      WIN_ONE: begin
        push.j0 = '{done: 1'b0, right: x, centre: centre, left: centre};
        push.n  = accept ? (s_axis_tlast ? 2'd2 : 2'd1) : 2'd0;
      end
      WIN_TWO: begin
        push.n  = accept ? (s_axis_tlast ? 2'd2 : 2'd1) : 2'd0;
      end
      default: begin
        push.n  = 2'd0;
      end
    endcase
  end

  // Advance the window
  always_ff @(posedge clk) begin
    if (rst) begin
      win <= WIN_EMPTY;
    end else if (accept) begin
      if (s_axis_tlast) begin
        win <= WIN_EMPTY;
      end else if (win == WIN_EMPTY) begin
        win <= WIN_ONE;
      end else begin
        win <= WIN_TWO;
      end
    end
  end

  // Shift columns in
  always_ff @(posedge clk) begin
    if (accept && !s_axis_tlast) begin
      left   <= centre;
      centre <= x;
    end
  end

endmodule

/* design/gss_queue.sv */
// Short job queue between the front end and the arithmetic back end.
module gss_queue (
  input  logic               clk,
  input  logic               rst,
  input  gss_pkg::gss_push_t push,
  output logic               room2,
  input  logic               pop,
  output logic               q_valid,
  output gss_pkg::job_t      head
);
  import gss_pkg::*;

  job_t              mem [QDEPTH];
  logic [QPTR_W-1:0] wptr;
  logic [QPTR_W-1:0] rptr;
  logic [QCNT_W-1:0] count;
  logic [QPTR_W-1:0] wptr1;

  assign wptr1   = wptr + QPTR_W'(1);
  assign room2   = count <= QCNT_W'(QDEPTH - 2);
  assign q_valid = count != '0;
  assign head    = mem[rptr];

  // Store up to two jobs per cycle
  always_ff @(posedge clk) begin
    if (push.n != 2'd0) begin
      mem[wptr] <= push.j0;
    end
    if (push.n == 2'd2) begin
      mem[wptr1] <= push.j1;
    end
  end

  // Track pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      wptr  <= wptr + QPTR_W'(push.n);
      rptr  <= rptr + QPTR_W'(pop);
      count <= count + QCNT_W'(push.n) - QCNT_W'(pop);
    end
  end

endmodule

/* design/gss_back.sv */
// Arithmetic back end: Laplacian, reaction terms, divide, time step, saturate.
module gss_back (
  input  logic                      clk,
  input  logic                      rst,
  input  gss_pkg::gss_cfg_t         cfg,
  input  logic                      q_valid,
  input  gss_pkg::job_t             head,
  output logic                      pop,
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  output logic [gss_pkg::RES_W-1:0] m_axis_tdata,
  output logic                      m_axis_tlast
);
  import gss_pkg::*;

  typedef enum logic [11:0] {
    S_IDLE = 12'b000000000001,
    S_MUL1 = 12'b000000000010,
    S_MUL2 = 12'b000000000100,
    S_SUM  = 12'b000000001000,
    S_DIVL = 12'b000000010000,
    S_DIVH = 12'b000000100000,
    S_DIVR = 12'b000001000000,
    S_DIVQ = 12'b000010000000,
    S_QOFF = 12'b000100000000,
    S_MULQ = 12'b001000000000,
    S_COMB = 12'b010000000000,
    S_OUT  = 12'b100000000000
  } state_t;

  // Corners + 4 * sides - 20 * centre
  function automatic logic signed [21:0] lap20(
    input logic [15:0] c0, input logic [15:0] c1,
    input logic [15:0] c2, input logic [15:0] c3,
    input logic [15:0] s0, input logic [15:0] s1,
    input logic [15:0] s2, input logic [15:0] s3,
    input logic [15:0] mid
  );
    logic [20:0] pos;
    logic [20:0] neg;
    pos = 21'(c0) + 21'(c1) + 21'(c2) + 21'(c3)
        + ((21'(s0) + 21'(s1) + 21'(s2) + 21'(s3)) << 2);
    neg = (21'(mid) << 4) + (21'(mid) << 2);
    return $signed({1'b0, pos}) - $signed({1'b0, neg});
  endfunction

  // Quotient by five of a value below 2^23, by reciprocal multiply
  function automatic logic [19:0] div5_small(input logic [22:0] x);
    logic [46:0] prod;
    prod = {24'b0, x} * {23'b0, RECIP5};
    return prod[45:26];
  endfunction

  state_t             state;
  logic [15:0]        a;
  logic [15:0]        b;
  logic               done;
  logic signed [21:0] lap_a;
  logic signed [21:0] lap_b;
  logic [31:0]        ab;
  logic signed [38:0] la;
  logic signed [38:0] lb;
  logic signed [34:0] fa;
  logic [32:0]        fkb;
  logic [47:0]        abb;
  logic signed [55:0] pa;
  logic signed [55:0] pb;
  logic signed [55:0] ma;
  logic signed [55:0] mb;
  logic [43:0]        dva;
  logic [43:0]        dvb;
  logic [18:0]        qha;
  logic [18:0]        qhb;
  logic [22:0]        xla;
  logic [22:0]        xlb;
  logic [19:0]        qla;
  logic [19:0]        qlb;
  logic signed [36:0] qa;
  logic signed [36:0] qb;
  logic [34:0]        loa;
  logic [34:0]        lob;
  logic signed [34:0] hia;
  logic signed [34:0] hib;
  logic signed [25:0] dlta;
  logic signed [25:0] dltb;

  logic [16:0]        fk_sum;
  logic signed [17:0] one_minus_a;
  logic signed [55:0] la_x;
  logic signed [55:0] lb_x;
  logic signed [55:0] fa_x;
  logic signed [55:0] fkb_x;
  logic signed [55:0] abb20;
  logic [20:0]        rha;
  logic [20:0]        rhb;
  logic [43:0]        qsa;
  logic [43:0]        qsb;
  logic signed [55:0] proda;
  logic signed [55:0] prodb;
  logic signed [26:0] va;
  logic signed [26:0] vb;
  logic [15:0]        new_a;
  logic [15:0]        new_b;
  logic               out_load;

  assign pop         = (state == S_IDLE) && q_valid;
  assign fk_sum      = {1'b0, cfg.feed} + {1'b0, cfg.kill};
  assign one_minus_a = 18'sd16384 - $signed({2'b00, a});
  assign la_x        = $signed({{17{la[38]}}, la});
  assign lb_x        = $signed({{17{lb[38]}}, lb});
  assign fa_x        = $signed({{21{fa[34]}}, fa});
  assign fkb_x       = $signed({23'b0, fkb});
  assign abb20       = $signed(({8'b0, abb} << 4) + ({8'b0, abb} << 2));
  assign rha         = dva[40:20] - ({qha, 2'b00} + {2'b00, qha});
  assign rhb         = dvb[40:20] - ({qhb, 2'b00} + {2'b00, qhb});
  assign qsa         = {5'b0, qha, qla} - Q_BIAS;
  assign qsb         = {5'b0, qhb, qlb} - Q_BIAS;
  assign proda       = $signed({{2{hia[34]}}, hia, 19'b0}) + $signed({21'b0, loa}) + DT_ROUND;
  assign prodb       = $signed({{2{hib[34]}}, hib, 19'b0}) + $signed({21'b0, lob}) + DT_ROUND;
  assign va          = $signed({11'b0, a}) + $signed({dlta[25], dlta});
  assign vb          = $signed({11'b0, b}) + $signed({dltb[25], dltb});
  assign out_load    = (state == S_OUT) && (!m_axis_tvalid || m_axis_tready);

  // Saturate to the UQ2.14 range
  always_comb begin
    if (va < 0) begin
      new_a = '0;
    end else if (va > 27'sd65535) begin
      new_a = '1;
    end else begin
      new_a = va[15:0];
    end
    if (vb < 0) begin
      new_b = '0;
    end else if (vb > 27'sd65535) begin
      new_b = '1;
    end else begin
      new_b = vb[15:0];
    end
  end

  // Sequence one pixel through the shared datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: begin
          if (q_valid) begin
            state <= S_MUL1;
          end
        end
        S_MUL1: state <= S_MUL2;
        S_MUL2: state <= S_SUM;
        S_SUM:  state <= S_DIVL;
        S_DIVL: state <= S_DIVH;
        S_DIVH: state <= S_DIVR;
        S_DIVR: state <= S_DIVQ;
        S_DIVQ: state <= S_QOFF;
        S_QOFF: state <= S_MULQ;
        S_MULQ: state <= S_COMB;
        S_COMB: state <= S_OUT;
        S_OUT: begin
          if (out_load) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        a     <= head.centre.mid_a;
        b     <= head.centre.mid_b;
        done  <= head.done;
        lap_a <= lap20(head.left.up_a, head.left.down_a, head.right.up_a,
                       head.right.down_a, head.centre.up_a, head.centre.down_a,
                       head.left.mid_a, head.right.mid_a, head.centre.mid_a);
        lap_b <= lap20(head.left.up_b, head.left.down_b, head.right.up_b,
                       head.right.down_b, head.centre.up_b, head.centre.down_b,
                       head.left.mid_b, head.right.mid_b, head.centre.mid_b);
      end
      S_MUL1: begin
        ab  <= a * b;
        la  <= $signed({1'b0, cfg.diff_a}) * lap_a;
        lb  <= $signed({1'b0, cfg.diff_b}) * lap_b;
        fa  <= $signed({1'b0, cfg.feed}) * one_minus_a;
        fkb <= fk_sum * b;
      end
      S_MUL2: begin
        abb <= ab * b;
        pa  <= (la_x <<< 14) + (fa_x <<< 18) + (fa_x <<< 16) + BR_ROUND;
        pb  <= (lb_x <<< 14) - (fkb_x <<< 18) - (fkb_x <<< 16) + BR_ROUND;
      end
      S_SUM: begin
        ma <= pa - abb20;
        mb <= pb + abb20;
      end
      S_DIVL: begin
        dva <= {{4{ma[55]}}, ma[55:16]} + DIV_BIAS;
        dvb <= {{4{mb[55]}}, mb[55:16]} + DIV_BIAS;
      end
      // Divide the upper 21 bits by five
      S_DIVH: begin
        qha <= 19'(div5_small({2'b00, dva[40:20]}));
        qhb <= 19'(div5_small({2'b00, dvb[40:20]}));
      end
      // Carry the upper remainder into the lower 20 bits
      S_DIVR: begin
        xla <= {rha[2:0], dva[19:0]};
        xlb <= {rhb[2:0], dvb[19:0]};
      end
      // Divide the lower part; it yields exactly 20 quotient bits
      S_DIVQ: begin
        qla <= div5_small(xla);
        qlb <= div5_small(xlb);
      end
      S_QOFF: begin
        qa <= $signed(qsa[36:0]);
        qb <= $signed(qsb[36:0]);
      end
      S_MULQ: begin
        loa <= qa[18:0] * cfg.dt;
        lob <= qb[18:0] * cfg.dt;
        hia <= $signed(qa[36:19]) * $signed({1'b0, cfg.dt});
        hib <= $signed(qb[36:19]) * $signed({1'b0, cfg.dt});
      end
      S_COMB: begin
        dlta <= proda[53:28];
        dltb <= prodb[53:28];
      end
      default: begin
      end
    endcase
  end

  // Output word register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_load) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_axis_tdata <= {new_b, new_a};
      m_axis_tlast <= done;
    end
  end

endmodule

/* design/gray_scott_stencil_step_top.sv */
// Top level of the Gray-Scott reaction-diffusion stencil update block.
// Takes one column of three pixels (A and B, UQ2.14) per input word and returns
// the updated centre pixel of the previous column: no word for the first column
// of a row, one for an inner column, two for the column marked tlast. Each
// result passes through the shared arithmetic unit, which holds the
// divide-by-five that rounds the bracket and starts a new pixel only once the
// previous result is in the output register. A four-deep job queue sits between
// the column window and the arithmetic, and a column is accepted whenever the
// queue has two free slots, so input and output stall independently.
module gray_scott_stencil_step_top (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [gss_pkg::CIDX_W-1:0]   cfg_index,
  input  logic [gss_pkg::VAL_W-1:0]    cfg_data,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  // up_a, up_b, mid_a, mid_b, down_a, down_b (16 bits each)
  input  logic [gss_pkg::COL_W-1:0]    s_axis_tdata,
  input  logic                         s_axis_tlast,
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  // new_a, new_b (16 bits each)
  output logic [gss_pkg::RES_W-1:0]    m_axis_tdata,
  output logic                         m_axis_tlast
);
  import gss_pkg::*;

  gss_cfg_t  cfg;
  gss_push_t push;
  job_t      head;
  logic      room2;
  logic      pop;
  logic      q_valid;

  // Rate registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.diff_a <= DIFF_A_RST;
      cfg.diff_b <= DIFF_B_RST;
      cfg.feed   <= FEED_RST;
      cfg.kill   <= KILL_RST;
      cfg.dt     <= DT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_DIFF_A: cfg.diff_a <= cfg_data;
        REG_DIFF_B: cfg.diff_b <= cfg_data;
        REG_FEED:   cfg.feed   <= cfg_data;
        REG_KILL:   cfg.kill   <= cfg_data;
        REG_DT:     cfg.dt     <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  gss_front u_front (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .room2         (room2),
    .push          (push)
  );

  gss_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .room2   (room2),
    .pop     (pop),
    .q_valid (q_valid),
    .head    (head)
  );

  gss_back u_back (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .q_valid       (q_valid),
    .head          (head),
    .pop           (pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule
